// ===== hw/rtl/gtww_pkg.sv =====
// types and constants shared by the greedy word-wrap block
// no dependencies; imported by every module of the block
package gtww_pkg;

   // fixed widths of the counters and fields
   localparam int CNT_W       = 6;
   localparam int CHAR_W      = 8;
   localparam int CMD_SLOTS   = 4;
   localparam int SLOT_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // special characters
   localparam logic [CHAR_W-1:0] NL_CHAR = 8'd10;
   localparam logic [CHAR_W-1:0] SP_CHAR = 8'd32;

   // register map and reset value
   localparam logic [CNT_W-1:0] LINE_WIDTH_RESET = 6'd32;
   localparam int CSR_ADDR_W = 2;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_out;
      logic              last_of_run;
   } rsp_type;

   // commands from the classifier to the emitter
   typedef enum logic [1:0] {
      OP_CHAR,
      OP_WORD,
      OP_STORE
   } cmd_op_type;

   // data_val: byte to emit or to store; len: word length or store index
   typedef struct packed {
      cmd_op_type        op;
      logic [CHAR_W-1:0] data_val;
      logic [CNT_W-1:0]  len;
      logic              last;
   } cmd_type;

endpackage

// ===== hw/rtl/gtww_front.sv =====
// classifier: takes a request, tracks column and held word, issues commands
// depends on gtww_pkg
module gtww_front import gtww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  req_type          req_payload,
   output logic             req_stall,
   input  logic [CNT_W-1:0] line_width,
   input  logic             q_full,
   output logic             push,
   output cmd_type          push_cmd
);

   localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  wlen_ff, wlen_in;
   logic              sp_ff, sp_in;
   logic              busy_ff, busy_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   cmd_type           slots_ff [CMD_SLOTS];
   cmd_type           slot_in  [CMD_SLOTS];
   logic [SLOT_W-1:0] n_cmd;
   logic [CNT_W-1:0]  w_eff;
   logic              full;
   logic              accept;
   logic [CHAR_W-1:0] c;

   function automatic cmd_type mk(cmd_op_type op, logic [CHAR_W-1:0] d,
                                  logic [CNT_W-1:0] l);
      cmd_type r;
      r.op       = op;
      r.data_val = d;
      r.len      = l;
      r.last     = 1'b0;
      return r;
   endfunction

   // effective line width and full-line test
   always_comb begin
      if (line_width == '0) begin
         w_eff = CNT_W'(1);
      end else if (line_width > MAX_W) begin
         w_eff = MAX_W;
      end else begin
         w_eff = line_width;
      end
      full = col_ff >= w_eff;
   end

   assign c         = req_payload.char_in;
   assign req_stall = busy_ff | q_full;
   assign accept    = req_valid & ~req_stall;

   // classify the request into a short command list and the next state
   always_comb begin
      for (int i = 0; i < CMD_SLOTS; i++) begin
         slot_in[i] = mk(OP_CHAR, '0, '0);
      end
      n_cmd   = '0;
      sp_in   = sp_ff;
      wlen_in = wlen_ff;
      col_in  = col_ff;

      if (c == NL_CHAR) begin
         if (sp_in) begin
            slot_in[n_cmd] = mk(OP_CHAR, SP_CHAR, '0);
            n_cmd = n_cmd + 1'b1;
         end
         if (wlen_in != '0) begin
            slot_in[n_cmd] = mk(OP_WORD, '0, wlen_in);
            n_cmd = n_cmd + 1'b1;
         end
         slot_in[n_cmd] = mk(OP_CHAR, NL_CHAR, '0);
         n_cmd   = n_cmd + 1'b1;
         sp_in   = 1'b0;
         wlen_in = '0;
         col_in  = '0;
      end else if (c == SP_CHAR) begin
         // settle the held space and word first
         if (sp_in) begin
            slot_in[n_cmd] = mk(OP_CHAR, SP_CHAR, '0);
            n_cmd = n_cmd + 1'b1;
         end
         if (wlen_in != '0) begin
            slot_in[n_cmd] = mk(OP_WORD, '0, wlen_in);
            n_cmd = n_cmd + 1'b1;
         end
         wlen_in = '0;
         if (full) begin
            slot_in[n_cmd] = mk(OP_CHAR, NL_CHAR, '0);
            n_cmd  = n_cmd + 1'b1;
            sp_in  = 1'b0;
            col_in = '0;
         end else begin
            sp_in  = 1'b1;
            col_in = col_ff + 1'b1;
         end
      end else if (full) begin
         slot_in[n_cmd] = mk(OP_CHAR, NL_CHAR, '0);
         n_cmd = n_cmd + 1'b1;
         if (sp_in) begin
            // held space becomes the break, the word is carried over
            if (wlen_in != '0) begin
               slot_in[n_cmd] = mk(OP_WORD, '0, wlen_in);
               n_cmd = n_cmd + 1'b1;
            end
            col_in = wlen_ff + 1'b1;
         end else begin
            col_in = CNT_W'(1);
         end
         slot_in[n_cmd] = mk(OP_CHAR, c, '0);
         n_cmd   = n_cmd + 1'b1;
         sp_in   = 1'b0;
         wlen_in = '0;
      end else if (sp_in) begin
         // hold the byte behind the pending space
         if (wlen_in < MAX_W) begin
            slot_in[n_cmd] = mk(OP_STORE, c, wlen_in);
            n_cmd   = n_cmd + 1'b1;
            wlen_in = wlen_in + 1'b1;
         end
         col_in = col_ff + 1'b1;
      end else begin
         slot_in[n_cmd] = mk(OP_CHAR, c, '0);
         n_cmd  = n_cmd + 1'b1;
         col_in = col_ff + 1'b1;
      end

      // end of text flushes everything held
      if (req_payload.end_of_text) begin
         if (sp_in) begin
            slot_in[n_cmd] = mk(OP_CHAR, SP_CHAR, '0);
            n_cmd = n_cmd + 1'b1;
         end
         if (wlen_in != '0) begin
            slot_in[n_cmd] = mk(OP_WORD, '0, wlen_in);
            n_cmd = n_cmd + 1'b1;
         end
         sp_in   = 1'b0;
         wlen_in = '0;
         col_in  = '0;
      end

      // mark the final command of the run when it produces output
      if (n_cmd != '0) begin
         if (slot_in[n_cmd - 1'b1].op != OP_STORE) begin
            slot_in[n_cmd - 1'b1].last = 1'b1;
         end
      end
   end

   // command issue: first command goes straight out, the rest from slots
   always_comb begin
      if (busy_ff) begin
         push     = ~q_full;
         push_cmd = slots_ff[ptr_ff];
      end else begin
         push     = accept & (n_cmd != '0);
         push_cmd = slot_in[0];
      end
      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      cnt_in  = cnt_ff;
      if (busy_ff) begin
         if (push) begin
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == cnt_ff - 1'b1) begin
               busy_in = 1'b0;
            end
         end
      end else if (accept && n_cmd > SLOT_W'(1)) begin
         busy_in = 1'b1;
         ptr_in  = SLOT_W'(1);
         cnt_in  = n_cmd;
      end
   end

   // state and sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         wlen_ff <= '0;
         sp_ff   <= 1'b0;
         busy_ff <= 1'b0;
         ptr_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         if (accept) begin
            col_ff  <= col_in;
            wlen_ff <= wlen_in;
            sp_ff   <= sp_in;
         end
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // command list, no reset needed
   always_ff @(posedge clock) begin
      if (!busy_ff && accept) begin
         slots_ff <= slot_in;
      end
   end

   // while issuing, the slot pointer stays inside the list
   a_ptr_in_list: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (ptr_ff < cnt_ff))
      else $error("front slot pointer beyond command list");

   // the held word never grows past the column
   a_word_in_line: assert property (@(posedge clock) disable iff (reset)
      sp_ff |-> (wlen_ff < col_ff))
      else $error("held word longer than the line");

endmodule

// ===== hw/rtl/gtww_queue.sv =====
// short command queue between classifier and emitter
// depends on gtww_pkg
module gtww_queue import gtww_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign full  = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("command queue read while empty");

endmodule

// ===== hw/rtl/gtww_back.sv =====
// emitter: carries out queued commands, owns the word store and output register
// depends on gtww_pkg
module gtww_back import gtww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type head,
   input  logic    empty,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [CHAR_W-1:0] word_mem [MAX_WIDTH];
   logic [CNT_W-1:0]  k_ff;
   logic              out_valid_ff;
   logic [CHAR_W-1:0] out_data_ff;
   logic              out_from_mem_ff;
   logic              out_last_ff;
   logic [CHAR_W-1:0] rd_data_ff;
   logic              out_free;
   logic              do_store, do_char, do_word;
   logic              word_end;

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign do_store = ~empty & (head.op == OP_STORE);
   assign do_char  = ~empty & (head.op == OP_CHAR) & out_free;
   assign do_word  = ~empty & (head.op == OP_WORD) & out_free;
   assign word_end = k_ff == head.len - 1'b1;
   assign pop      = do_store | do_char | (do_word & word_end);

   // word index walks the held word one byte a cycle while the output is not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (do_word) begin
            k_ff <= word_end ? '0 : k_ff + 1'b1;
         end
         if (do_char || do_word) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (do_char || do_word) begin
         out_data_ff     <= head.data_val;
         out_from_mem_ff <= do_word;
         out_last_ff     <= head.last & (do_char | word_end);
      end
   end

   // word store: one write and one registered read
   always_ff @(posedge clock) begin
      if (do_store) begin
         word_mem[head.len[IDX_W-1:0]] <= head.data_val;
      end
      if (do_word) begin
         rd_data_ff <= word_mem[k_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_payload.char_out = out_from_mem_ff ? rd_data_ff : out_data_ff;
   assign rsp_payload.last_of_run = out_last_ff;

   a_word_index: assert property (@(posedge clock) disable iff (reset)
      (!empty && head.op == OP_WORD) |-> (k_ff < head.len))
      else $error("word index past held word length");

endmodule

// ===== hw/rtl/greedy_text_word_wrap.sv =====
// Greedy word wrap: one text byte per request, re-flowed text out, one byte
// per response. A classifier issues up to three commands per request (emit a
// byte, emit the held word, store a byte) into a four-entry queue; an emitter
// runs one byte or store command per cycle and reads a held word from the
// word store one entry a cycle, while the output is not stalled. A request of
// one command or none is taken every cycle while the queue has room; one with
// more holds the request side while the rest issue, and word flushes set the
// sustained rate. line_width is to be written only while idle, unchecked.
// depends on gtww_pkg, gtww_front, gtww_queue, gtww_back
module greedy_text_word_wrap import gtww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_payload,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0] line_width_ff;
   logic             push, pop, q_full, q_empty;
   cmd_type          push_cmd, head;
   logic             csr_write;

   // configuration register, one word, decoded at every address
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = {{(32-CNT_W){1'b0}}, line_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_write && csr_paddr[CSR_ADDR_W-1:0] <= CSR_ADDR_W'(3)) begin
         line_width_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   gtww_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .line_width  (line_width_ff),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gtww_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   gtww_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (q_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/wrap_checker.sv =====
// checker for the greedy word-wrap block: watches the request, response and csr ports,
// predicts the wrapped text byte by byte and compares every accepted response
// depends on gtww_pkg for the payload types and the special characters
module wrap_checker import gtww_pkg::*; #(
   parameter int MAX_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [31:0]           csr_pwdata,
   output int                    mismatches,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // own copy of the wrap state
   logic [CNT_W-1:0]  width_cfg;
   logic [CNT_W-1:0]  line_col;
   logic [CHAR_W-1:0] word_buf [MAX_WIDTH];
   logic [CNT_W-1:0]  word_len;
   logic              space_held;

   // bytes still owed by the block, oldest first
   rsp_type           due_chars [$];
   logic [CHAR_W-1:0] staged_char;
   logic              have_staged;
   int                fail_cnt;
   rsp_type           want;

   initial begin
      fail_cnt = 0;
   end

   task automatic report_mismatch(input string what);
      fail_cnt++;
      $display("%0t ns: %s", $time, what);
   endtask

   // one byte is staged so that the last one of a request can be flagged
   task automatic emit_char(input logic [CHAR_W-1:0] c);
      rsp_type item;
      if (have_staged) begin
         item.char_out    = staged_char;
         item.last_of_run = 1'b0;
         due_chars.insert(due_chars.size(), item);
      end
      staged_char = c;
      have_staged = 1'b1;
   endtask

   task automatic emit_held_word();
      for (int k = 0; k < word_len; k++) emit_char(word_buf[k]);
      word_len = '0;
   endtask

   // held space and word go out unchanged
   task automatic settle_held();
      if (space_held) emit_char(SP_CHAR);
      space_held = 1'b0;
      emit_held_word();
   endtask

   task automatic reflow_byte(input req_type r);
      int      w;
      logic    full;
      int      carried;
      rsp_type item;
      w = width_cfg;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      // a column left above a lowered width counts as full
      full = (line_col >= w);
      have_staged = 1'b0;

      if (r.char_in == NL_CHAR) begin
         settle_held();
         emit_char(NL_CHAR);
         line_col = '0;
      end else if (r.char_in == SP_CHAR) begin
         settle_held();
         if (full) begin
            emit_char(NL_CHAR);
            line_col = '0;
         end else begin
            space_held = 1'b1;
            line_col++;
         end
      end else if (full) begin
         if (space_held) begin
            // held space turns into the break, the word moves down
            carried    = word_len;
            space_held = 1'b0;
            emit_char(NL_CHAR);
            emit_held_word();
            emit_char(r.char_in);
            line_col = carried + 1;
         end else begin
            // no space on the line: hard break
            emit_char(NL_CHAR);
            emit_char(r.char_in);
            line_col = 1;
         end
      end else if (space_held) begin
         if (word_len < MAX_WIDTH) begin
            word_buf[word_len] = r.char_in;
            word_len++;
         end
         line_col++;
      end else begin
         emit_char(r.char_in);
         line_col++;
      end

      // end of text flushes whatever is held
      if (r.end_of_text) begin
         settle_held();
         line_col = '0;
      end

      if (have_staged) begin
         item.char_out    = staged_char;
         item.last_of_run = 1'b1;
         due_chars.insert(due_chars.size(), item);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_cfg  = LINE_WIDTH_RESET;
         line_col   = '0;
         word_len   = '0;
         space_held = 1'b0;
         due_chars.delete();
      end else begin
         // the port holds a single register
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            width_cfg = csr_pwdata[CNT_W-1:0];

         // request first, in case its response is passed straight through
         if (req_valid && !req_stall) reflow_byte(req_payload);

         if (rsp_valid && !rsp_stall) begin
            if (due_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected output byte %0d",
                                         rsp_payload.char_out));
            end else begin
               want = due_chars.pop_front();
               if (rsp_payload.char_out !== want.char_out)
                  report_mismatch($sformatf("char_out %0d, predicted %0d",
                                            rsp_payload.char_out, want.char_out));
               if (rsp_payload.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %0b, predicted %0b on byte %0d",
                                            rsp_payload.last_of_run, want.last_of_run,
                                            want.char_out));
            end
         end
      end
      mismatches  <= fail_cnt;
      outstanding <= due_chars.size();
   end

endmodule

// ===== tb/tb.sv =====
// top of the greedy word-wrap testbench: clock, reset, text stimulus, csr writes
// and the final verdict; depends on gtww_pkg, greedy_text_word_wrap and wrap_checker
module tb import gtww_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W = 32;
   localparam logic [CSR_ADDR_W-1:0] LINE_WIDTH_ADDR = '0;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   req_type               req_payload = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int outstanding;
   bit calm = 1'b0;
   int stall_hold = 0;
   int phase_widths [10] = '{0, 40, 1, 63, 9, 20, 3, 32, 12, 5};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   greedy_text_word_wrap #(.MAX_WIDTH(MAX_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wrap_checker #(.MAX_WIDTH(MAX_W)) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // response back-pressure: runs of stall and of flow, mostly short
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= !calm && ($urandom_range(0, 2) == 0);
         stall_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 25);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // one request; valid stays high when no gap follows
   task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_payload.char_in     <= c;
      req_payload.end_of_text <= eot;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every predicted byte is out, then let the queue empty
   task automatic wait_for_output_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (16) @(posedge clock);
   endtask

   // upper data bits are junk, only the low six are kept
   task automatic write_line_width(input logic [CNT_W-1:0] w);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LINE_WIDTH_ADDR;
      csr_pwdata  <= ($urandom() & 32'hFFFF_FFC0) | 32'(w);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // words of random length between separators, with some noise bytes
   task automatic send_text(input int count, input bit close_text);
      int          word_left;
      int          r;
      logic [7:0]  c;
      logic        eot;
      word_left = 0;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (word_left > 0) begin
            c = (r < 90) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(0, 255));
            word_left--;
         end else begin
            if (r < 75)      c = SP_CHAR;
            else if (r < 87) c = NL_CHAR;
            else             c = 8'($urandom_range(0, 255));
            word_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6)
                                                    : $urandom_range(7, 40);
         end
         eot = (close_text && n == count - 1) || ($urandom_range(0, 99) < 2);
         send_byte(c, eot);
      end
   endtask

   initial begin
      string opening;
      string closing;
      int    guard;
      opening = "ab cdxyzpq rst  ";
      closing = " m\n n k";

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // narrow line: back-step, hard break, empty carried word, space on full line
      write_line_width(4);
      for (int i = 0; i < opening.len(); i++) send_byte(opening[i], 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(NL_CHAR, 1'b0);
      // word settled by newline, by a later space, then flushed by end of text
      for (int i = 0; i < closing.len(); i++)
         send_byte(closing[i], i == closing.len() - 1);
      wait_for_output_drain();

      // random phases; odd phases leave a line open for the narrower one after
      for (int p = 0; p < 10; p++) begin
         write_line_width(phase_widths[p][CNT_W-1:0]);
         calm = (p % 4 == 2);
         if (p == 3) begin
            send_text(16, 1'b0);
            wait_for_output_drain();
            send_text(16, 1'b0);
         end else begin
            send_text(32, p % 2 == 0);
         end
         wait_for_output_drain();
      end

      // let any late or stray bytes show up
      req_valid <= 1'b0;
      for (guard = 0; guard < 50000 && outstanding != 0; guard++) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         if (outstanding != 0) $display("%0d predicted bytes never came", outstanding);
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
